FILE: rtl/nbg_pkg.sv
// nbg_pkg: shared types, opcodes and constants for the n-body acceleration core
// no dependencies; imported by nbg_serial_unit and nbody_gravity_accel_core
package nbg_pkg;

    localparam int MAX_BODIES_DEF = 64;
    localparam int MUL_ITER  = 64;
    localparam int DIV_ITER  = 128;
    localparam int SQRT_ITER = 34;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_GRAV_CONST   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOFTENING_SQ = 2'd1;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } nbg_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RDI,
        S_LDI,
        S_RDJ,
        S_LDJ,
        S_SQ,
        S_CHK,
        S_SQRT,
        S_DEN,
        S_GM,
        S_NUM,
        S_DIV,
        S_NEXTJ,
        S_OUT
    } nbg_state_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [31:0]        body_mass;
        logic               last_body;
    } nbg_body_t;

    typedef struct packed {
        logic [5:0]         body_index;
        logic signed [47:0] acc_x;
        logic signed [47:0] acc_y;
        logic signed [47:0] acc_z;
        logic               last_result;
    } nbg_result_t;

    // command to the shared serial unit
    typedef struct packed {
        logic         go;
        nbg_op_t      op;
        logic [127:0] opa;
        logic [63:0]  opb;
        logic [103:0] opd;
        logic [127:0] init;
    } nbg_cmd_t;

    typedef struct packed {
        logic         done;
        logic [127:0] value;
        logic [48:0]  quot;
        logic         qovf;
    } nbg_rsp_t;

endpackage

FILE: rtl/nbg_serial_unit.sv
// nbg_serial_unit: one bit per cycle shift-add multiply, restoring divide and sqrt
// depends on nbg_pkg
module nbg_serial_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  nbg_pkg::nbg_cmd_t cmd,
    output nbg_pkg::nbg_rsp_t rsp
);
    import nbg_pkg::*;

    nbg_op_t      op_reg;
    logic         run_reg, run_next;
    logic         done_reg, done_next;
    logic [7:0]   cnt_reg, cnt_next;
    logic [127:0] a_reg, a_next;
    logic [63:0]  b_reg, b_next;
    logic [103:0] d_reg;
    logic [127:0] r_reg, r_next;
    logic [48:0]  q_reg, q_next;
    logic         ovf_reg, ovf_next;

    logic [104:0] div_sh;
    logic [105:0] div_diff;
    logic [39:0]  sq_sh;
    logic [40:0]  sq_diff;

    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        r_next    = r_reg;
        q_next    = q_reg;
        ovf_next  = ovf_reg;
        run_next  = run_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        div_sh    = {r_reg[103:0], a_reg[127]};
        div_diff  = {1'b0, div_sh} - {2'b00, d_reg};
        sq_sh     = {r_reg[37:0], a_reg[127:126]};
        sq_diff   = {1'b0, sq_sh} - {3'b000, q_reg[35:0], 2'b01};
        if (run_reg)
        begin
            case (op_reg)
                OP_MUL:
                begin
                    if (b_reg[0])
                    begin
                        r_next = r_reg + a_reg;
                    end
                    a_next = a_reg << 1;
                    b_next = b_reg >> 1;
                end
                OP_DIV:
                begin
                    a_next   = a_reg << 1;
                    ovf_next = ovf_reg | q_reg[48];
                    if (!div_diff[105])
                    begin
                        r_next = {23'd0, div_diff[104:0]};
                        q_next = {q_reg[47:0], 1'b1};
                    end
                    else
                    begin
                        r_next = {23'd0, div_sh};
                        q_next = {q_reg[47:0], 1'b0};
                    end
                end
                OP_SQRT:
                begin
                    a_next = a_reg << 2;
                    if (!sq_diff[40])
                    begin
                        r_next = {88'd0, sq_diff[39:0]};
                        q_next = {q_reg[47:0], 1'b1};
                    end
                    else
                    begin
                        r_next = {88'd0, sq_sh};
                        q_next = {q_reg[47:0], 1'b0};
                    end
                end
                default:
                begin
                    r_next = r_reg;
                end
            endcase
            cnt_next = cnt_reg - 8'd1;
            if (cnt_reg == 8'd1)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (cmd.go)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            case (cmd.op)
                OP_MUL:  cnt_reg <= 8'(MUL_ITER);
                OP_DIV:  cnt_reg <= 8'(DIV_ITER);
                default: cnt_reg <= 8'(SQRT_ITER);
            endcase
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.go)
        begin
            op_reg  <= cmd.op;
            a_reg   <= cmd.opa;
            b_reg   <= cmd.opb;
            d_reg   <= cmd.opd;
            r_reg   <= cmd.init;
            q_reg   <= '0;
            ovf_reg <= 1'b0;
        end
        else
        begin
            a_reg   <= a_next;
            b_reg   <= b_next;
            r_reg   <= r_next;
            q_reg   <= q_next;
            ovf_reg <= ovf_next;
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.value = r_reg;
    assign rsp.quot  = q_reg;
    assign rsp.qovf  = ovf_reg;

endmodule

FILE: rtl/nbody_gravity_accel_core.sv
// nbody_gravity_accel_core: direct-sum softened gravity over a stored body set
// depends on nbg_pkg and nbg_serial_unit
// operation: a last_body request starts the set; each ordered pair of distinct bodies
//   with nonzero s takes 8 multiplies, one sqrt and three divides on the one shared
//   serial unit; results come one per body, each one cycle wide, no stall
// reset: counts, control and config registers clear; the body store holds garbage until loaded
module nbody_gravity_accel_core #(
    parameter int MAX_BODIES = nbg_pkg::MAX_BODIES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  nbg_pkg::nbg_body_t             body,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [nbg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [63:0]                    cfg_data,
    output logic                           result_valid,
    output nbg_pkg::nbg_result_t           result
);
    import nbg_pkg::*;

    localparam int IDX_W = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
    localparam int CNT_W = $clog2(MAX_BODIES + 1);
    localparam logic [47:0] QLIM = 48'h8000_0000_0000;
    localparam logic signed [53:0] ACC_MAX = 54'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [53:0] ACC_MIN = -54'sh0_8000_0000_0000;

    // body store: {mass, z, y, x}, one write and one registered read port
    logic [127:0] store_mem [MAX_BODIES];
    logic [127:0] rd_data_reg;
    logic [IDX_W-1:0] rd_addr;

    // config registers
    logic [31:0] grav_reg;
    logic [63:0] soft_reg;

    // sequencer
    nbg_state_t state_reg, state_next;
    logic             issued_reg, issued_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [1:0]       axis_reg, axis_next;

    // pair datapath
    logic signed [31:0] pi_reg [3];
    logic signed [31:0] pi_next [3];
    logic [32:0]        mag_reg [3];
    logic [32:0]        mag_next [3];
    logic [2:0]         neg_reg, neg_next;
    logic [31:0]        mass_reg, mass_next;
    logic [66:0]        s_reg, s_next;
    logic [33:0]        root_reg, root_next;
    logic [100:0]       den_reg, den_next;
    logic [63:0]        gm_reg, gm_next;
    logic [96:0]        num_reg, num_next;
    logic signed [53:0] acc_reg [3];
    logic signed [53:0] acc_next [3];

    logic               out_strobe;
    nbg_result_t        res_next;
    logic               valid_reg;
    nbg_result_t        res_reg;

    nbg_cmd_t cmd;
    nbg_rsp_t rsp;

    logic               accept;
    logic               room;
    logic signed [32:0] dlt [3];
    logic signed [31:0] pj [3];
    logic [47:0]        qm;
    logic signed [53:0] term;
    logic signed [53:0] sat [3];

    nbg_serial_unit u_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rsp   (rsp)
    );

    assign accept    = start && !busy;
    assign room      = count_reg < CNT_W'(MAX_BODIES);
    assign busy      = (state_reg != S_IDLE);
    // registers only change while no set is being computed
    assign cfg_ready = !busy;

    // positions of the body just read (j, or i in S_LDI) straight from the store read register
    assign pj[0] = rd_data_reg[31:0];
    assign pj[1] = rd_data_reg[63:32];
    assign pj[2] = rd_data_reg[95:64];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            dlt[k] = {pj[k][31], pj[k]} - {pi_reg[k][31], pi_reg[k]};
        end
        // saturate the per-pair quotient to the 2^47 ceiling
        if (rsp.qovf || (rsp.quot > {1'b0, QLIM}))
        begin
            qm = QLIM;
        end
        else
        begin
            qm = rsp.quot[47:0];
        end
        term = neg_reg[axis_reg] ? -$signed({6'd0, qm}) : $signed({6'd0, qm});
        for (int k = 0; k < 3; k++)
        begin
            if (acc_reg[k] > ACC_MAX)
            begin
                sat[k] = ACC_MAX;
            end
            else if (acc_reg[k] < ACC_MIN)
            begin
                sat[k] = ACC_MIN;
            end
            else
            begin
                sat[k] = acc_reg[k];
            end
        end
    end

    // next state, datapath and unit commands
    always_comb
    begin
        state_next  = state_reg;
        issued_next = issued_reg;
        count_next  = count_reg;
        n_next      = n_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        axis_next   = axis_reg;
        pi_next     = pi_reg;
        mag_next    = mag_reg;
        neg_next    = neg_reg;
        mass_next   = mass_reg;
        s_next      = s_reg;
        root_next   = root_reg;
        den_next    = den_reg;
        gm_next     = gm_reg;
        num_next    = num_reg;
        acc_next    = acc_reg;
        out_strobe  = 1'b0;
        rd_addr     = j_reg[IDX_W-1:0];
        cmd.go      = 1'b0;
        cmd.op      = OP_MUL;
        cmd.opa     = '0;
        cmd.opb     = '0;
        cmd.opd     = '0;
        cmd.init    = '0;

        res_next.body_index  = 6'(i_reg);
        res_next.acc_x       = sat[0][47:0];
        res_next.acc_y       = sat[1][47:0];
        res_next.acc_z       = sat[2][47:0];
        res_next.last_result = (i_reg + CNT_W'(1)) == n_reg;

        // operation states issue each command once, then wait for the unit
        if (!issued_reg && (state_reg == S_SQ || state_reg == S_SQRT ||
            state_reg == S_DEN || state_reg == S_GM || state_reg == S_NUM ||
            state_reg == S_DIV))
        begin
            cmd.go      = 1'b1;
            issued_next = 1'b1;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (room)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (body.last_body)
                    begin
                        n_next     = room ? count_reg + CNT_W'(1) : count_reg;
                        i_next     = '0;
                        state_next = S_RDI;
                    end
                end
            end
            S_RDI:
            begin
                rd_addr    = i_reg[IDX_W-1:0];
                state_next = S_LDI;
            end
            S_LDI:
            begin
                pi_next[0] = pj[0];
                pi_next[1] = pj[1];
                pi_next[2] = pj[2];
                j_next     = '0;
                for (int k = 0; k < 3; k++)
                begin
                    acc_next[k] = '0;
                end
                state_next = S_RDJ;
            end
            S_RDJ:
            begin
                if (j_reg == n_reg)
                begin
                    state_next = S_OUT;
                end
                else if (j_reg == i_reg)
                begin
                    j_next = j_reg + CNT_W'(1);
                end
                else
                begin
                    state_next = S_LDJ;
                end
            end
            S_LDJ:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    neg_next[k] = dlt[k][32];
                    mag_next[k] = dlt[k][32] ? 33'(-dlt[k]) : 33'(dlt[k]);
                end
                mass_next  = rd_data_reg[127:96];
                s_next     = {3'd0, soft_reg};
                axis_next  = 2'd0;
                state_next = S_SQ;
            end
            S_SQ:
            begin
                // s accumulates softening plus the three squared offsets
                cmd.op   = OP_MUL;
                cmd.opa  = {95'd0, mag_reg[axis_reg]};
                cmd.opb  = {31'd0, mag_reg[axis_reg]};
                cmd.init = {61'd0, s_reg};
                if (issued_reg && rsp.done)
                begin
                    issued_next = 1'b0;
                    s_next      = rsp.value[66:0];
                    if (axis_reg == 2'd2)
                    begin
                        state_next = S_CHK;
                    end
                    else
                    begin
                        axis_next = axis_reg + 2'd1;
                    end
                end
            end
            S_CHK:
            begin
                // coincident bodies with no softening add nothing
                state_next = (s_reg == '0) ? S_NEXTJ : S_SQRT;
            end
            S_SQRT:
            begin
                cmd.op  = OP_SQRT;
                cmd.opa = {1'b0, s_reg, 60'd0};
                if (issued_reg && rsp.done)
                begin
                    issued_next = 1'b0;
                    root_next   = rsp.quot[33:0];
                    state_next  = S_DEN;
                end
            end
            S_DEN:
            begin
                cmd.op  = OP_MUL;
                cmd.opa = {61'd0, s_reg};
                cmd.opb = {30'd0, root_reg};
                if (issued_reg && rsp.done)
                begin
                    issued_next = 1'b0;
                    den_next    = rsp.value[100:0];
                    state_next  = S_GM;
                end
            end
            S_GM:
            begin
                cmd.op  = OP_MUL;
                cmd.opa = {96'd0, grav_reg};
                cmd.opb = {32'd0, mass_reg};
                if (issued_reg && rsp.done)
                begin
                    issued_next = 1'b0;
                    gm_next     = rsp.value[63:0];
                    axis_next   = 2'd0;
                    state_next  = S_NUM;
                end
            end
            S_NUM:
            begin
                cmd.op  = OP_MUL;
                cmd.opa = {64'd0, gm_reg};
                cmd.opb = {31'd0, mag_reg[axis_reg]};
                if (issued_reg && rsp.done)
                begin
                    issued_next = 1'b0;
                    num_next    = rsp.value[96:0];
                    state_next  = S_DIV;
                end
            end
            S_DIV:
            begin
                // numerator carries the 2^24 output scale in its low zeros
                cmd.op  = OP_DIV;
                cmd.opa = {7'd0, num_reg, 24'd0};
                cmd.opd = {3'd0, den_reg};
                if (issued_reg && rsp.done)
                begin
                    issued_next        = 1'b0;
                    acc_next[axis_reg] = acc_reg[axis_reg] + term;
                    if (axis_reg == 2'd2)
                    begin
                        state_next = S_NEXTJ;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = S_NUM;
                    end
                end
            end
            S_NEXTJ:
            begin
                j_next     = j_reg + CNT_W'(1);
                state_next = S_RDJ;
            end
            S_OUT:
            begin
                out_strobe = 1'b1;
                i_next     = i_reg + CNT_W'(1);
                if ((i_reg + CNT_W'(1)) == n_reg)
                begin
                    count_next = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_RDI;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            issued_reg <= 1'b0;
            count_reg  <= '0;
            n_reg      <= '0;
            i_reg      <= '0;
            j_reg      <= '0;
            axis_reg   <= '0;
            valid_reg  <= 1'b0;
            grav_reg   <= '0;
            soft_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            issued_reg <= issued_next;
            count_reg  <= count_next;
            n_reg      <= n_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            axis_reg   <= axis_next;
            valid_reg  <= out_strobe;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_GRAV_CONST:   grav_reg <= cfg_data[31:0];
                    REG_SOFTENING_SQ: soft_reg <= cfg_data;
                    default:          grav_reg <= grav_reg;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pi_reg   <= pi_next;
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        mass_reg <= mass_next;
        s_reg    <= s_next;
        root_reg <= root_next;
        den_reg  <= den_next;
        gm_reg   <= gm_next;
        num_reg  <= num_next;
        acc_reg  <= acc_next;
        if (out_strobe)
        begin
            res_reg <= res_next;
        end
    end

    // body store
    always_ff @(posedge clk)
    begin
        if (accept && room)
        begin
            store_mem[count_reg[IDX_W-1:0]] <= {body.body_mass, body.pos_z,
                                                body.pos_y, body.pos_x};
        end
        rd_data_reg <= store_mem[rd_addr];
    end

    assign result_valid = valid_reg;
    assign result       = res_reg;

    // a result only follows the output state
    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(state_reg == S_OUT))
        else $error("result strobe without output state");

    // the final result of a set leaves the store empty and the block idle
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last_result |-> count_reg == '0 && !busy)
        else $error("store not cleared after final result");

    // the fill count never passes the store depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_BODIES))
        else $error("body count past store depth");

    // the unit is only started while computing
    a_go_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.go |-> busy && !$past(cmd.go))
        else $error("unit started while idle or twice");

endmodule

FILE: bench/tb_nbody_gravity_accel_core.sv
// tb_nbody_gravity_accel_core: self-checking bench for the softened n-body acceleration core
// depends on nbg_pkg and the rtl of nbody_gravity_accel_core; loads body sets, predicts
// every per-body acceleration in exact wide arithmetic and checks each result in order
module tb_nbody_gravity_accel_core;
    timeunit 1ns;
    timeprecision 1ps;

    import nbg_pkg::*;

    localparam int          STORE_DEPTH = 64;
    localparam longint      CYCLE_LIMIT = 40_000_000;
    // drain pause after the last result
    localparam int          DRAIN_PAUSE = 20;
    // indexes past the register list, written to check they are ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
    localparam logic [63:0] LIM47 = 64'h0000_8000_0000_0000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    nbg_body_t   body = '0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [63:0] cfg_data = '0;
    logic        result_valid;
    nbg_result_t result;

    nbody_gravity_accel_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .body         (body),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result       (result)
    );

    always #4 clk = ~clk;

    // shadow copy of the block state
    logic [31:0] grav_shadow;
    logic [63:0] soft_shadow;
    longint      pos_mem [STORE_DEPTH][3];
    logic [31:0] mass_mem [STORE_DEPTH];
    int          loaded;

    nbg_result_t accel_q [$];
    int          error_count = 0;
    int          requests_sent;
    int          results_seen = 0;
    int          sets_done;
    int          gap_pct;
    longint      cycle_count = 0;

    // cycle cap guards against a hung block
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_nbody_gravity_accel_core: done, errors");
            $finish;
        end
    end

    function automatic logic [63:0] floor_sqrt(input logic [127:0] s);
        logic [63:0]  root;
        logic [127:0] cand;
        root = '0;
        for (int b = 33; b >= 0; b--) begin
            cand = {64'b0, root | (64'd1 << b)};
            if (s >= cand * cand)
                root = cand[63:0];
        end
        return root;
    endfunction

    // pairwise sums over the stored set, one expected result per body
    task automatic predict_accel_set();
        longint      acc [3];
        longint      d [3];
        logic [63:0] mag [3];
        logic [127:0] s, den, gm, num, q;
        logic [63:0] root, qm;
        nbg_result_t r;
        for (int i = 0; i < loaded; i++) begin
            acc = '{0, 0, 0};
            for (int j = 0; j < loaded; j++) begin
                if (j == i)
                    continue;
                s = {64'b0, soft_shadow};
                for (int k = 0; k < 3; k++) begin
                    d[k] = pos_mem[j][k] - pos_mem[i][k];
                    mag[k] = d[k] < 0 ? 64'(-d[k]) : 64'(d[k]);
                    s = s + {64'b0, mag[k]} * {64'b0, mag[k]};
                end
                // coincident bodies without softening contribute nothing
                if (s == 0)
                    continue;
                root = floor_sqrt(s);
                den = s * {64'b0, root};
                gm = {96'b0, grav_shadow} * {96'b0, mass_mem[j]};
                for (int k = 0; k < 3; k++) begin
                    num = (gm * {64'b0, mag[k]}) << 24;
                    q = num / den;
                    qm = (q > {64'b0, LIM47}) ? LIM47 : q[63:0];
                    acc[k] += d[k] < 0 ? -longint'(qm) : longint'(qm);
                end
            end
            for (int k = 0; k < 3; k++) begin
                if (acc[k] > longint'(LIM47 - 1))
                    acc[k] = longint'(LIM47 - 1);
                if (acc[k] < -longint'(LIM47))
                    acc[k] = -longint'(LIM47);
            end
            r.body_index  = 6'(i);
            r.acc_x       = acc[0][47:0];
            r.acc_y       = acc[1][47:0];
            r.acc_z       = acc[2][47:0];
            r.last_result = (i + 1 == loaded);
            accel_q = {accel_q, r};
        end
        loaded = 0;
        sets_done++;
    endtask

    // one load request; start stays high afterwards unless a gap follows
    task automatic send_body(input nbg_body_t b);
        start <= 1'b1;
        body  <= b;
        do @(posedge clk); while (busy);
        requests_sent++;
        if (loaded < STORE_DEPTH) begin
            pos_mem[loaded][0] = longint'(b.pos_x);
            pos_mem[loaded][1] = longint'(b.pos_y);
            pos_mem[loaded][2] = longint'(b.pos_z);
            mass_mem[loaded]   = b.body_mass;
            loaded++;
        end
        if (b.last_body)
            predict_accel_set();
        if ($urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (accel_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_PAUSE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_GRAV_CONST)
            grav_shadow = val[31:0];
        else if (idx == REG_SOFTENING_SQ)
            soft_shadow = val;
        @(posedge clk);
    endtask

    function automatic nbg_body_t mk_body(input logic signed [31:0] x, y, z,
                                          input logic [31:0] m, input logic last);
        nbg_body_t b;
        b.pos_x = x; b.pos_y = y; b.pos_z = z;
        b.body_mass = m; b.last_body = last;
        return b;
    endfunction

    // each coordinate sits near a shared center half the time so the sums stay meaningful
    function automatic nbg_body_t rand_body(input logic [31:0] center, input logic last);
        logic [31:0] c [3];
        logic [31:0] m;
        for (int k = 0; k < 3; k++)
            c[k] = ($urandom_range(1)) ? $urandom()
                                       : center + 32'($urandom_range(0, 32'h3F_FFFF)) - 32'h20_0000;
        case ($urandom_range(3))
            0: m = $urandom();
            1: m = $urandom_range(0, 1000);
            2: m = 32'hFFFF_FFFF;
            default: m = $urandom_range(0, 1);
        endcase
        return mk_body(c[0], c[1], c[2], m, last);
    endfunction

    // result checker: strobe is one cycle, the receiver cannot stall
    always @(posedge clk) begin
        nbg_result_t want;
        if (rst_n && result_valid) begin
            results_seen++;
            if (accel_q.size() == 0) begin
                $error("unexpected result, body_index %0d", result.body_index);
                error_count++;
            end else begin
                want = accel_q.pop_front();
                if (result.body_index !== want.body_index) begin
                    $error("body_index expected %0d got %0d", want.body_index, result.body_index);
                    error_count++;
                end
                if (result.acc_x !== want.acc_x) begin
                    $error("acc_x expected %0d got %0d", want.acc_x, result.acc_x);
                    error_count++;
                end
                if (result.acc_y !== want.acc_y) begin
                    $error("acc_y expected %0d got %0d", want.acc_y, result.acc_y);
                    error_count++;
                end
                if (result.acc_z !== want.acc_z) begin
                    $error("acc_z expected %0d got %0d", want.acc_z, result.acc_z);
                    error_count++;
                end
                if (result.last_result !== want.last_result) begin
                    $error("last_result expected %0d got %0d",
                           want.last_result, result.last_result);
                    error_count++;
                end
            end
        end
    end

    task automatic test_single_body();
        write_reg(REG_GRAV_CONST, 64'hFFFF_FFFF);
        write_reg(REG_SOFTENING_SQ, 64'h0);
        send_body(mk_body(32'sh0001_0000, -32'sh0002_0000, 32'sh0, 32'd5, 1'b1));
        drain();
    endtask

    task automatic test_coincident_and_saturation();
        // same spot with no softening, then near neighbors with everything at max
        send_body(mk_body(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0, 32'hFFFF_FFFF, 1'b0));
        send_body(mk_body(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0, 32'hFFFF_FFFF, 1'b0));
        send_body(mk_body(32'sh7FFF_FFFE, 32'sh8000_0000, 32'sh1, 32'hFFFF_FFFF, 1'b0));
        send_body(mk_body(32'sh7FFF_FFFF, 32'sh8000_0001, -32'sh1, 32'hFFFF_FFFF, 1'b1));
        drain();
    endtask

    task automatic test_zero_mass_and_extremes();
        write_reg(REG_GRAV_CONST, 64'h0001_0000);
        write_reg(REG_SOFTENING_SQ, 64'hFFFF_FFFF_FFFF_FFFF);
        send_body(mk_body(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'hFFFF_FFFF, 1'b0));
        send_body(mk_body(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'h0, 1'b0));
        send_body(mk_body(32'sh0, 32'sh0, 32'sh0, 32'h0, 1'b1));
        drain();
        write_reg(REG_SOFTENING_SQ, 64'h0000_0001_0000_0000);
        send_body(mk_body(32'sh0, 32'sh0, 32'sh0, 32'd1000, 1'b0));
        send_body(mk_body(32'sh0003_0000, 32'sh0004_0000, 32'sh0, 32'd0, 1'b0));
        send_body(mk_body(-32'sh0001_8000, 32'sh0, 32'sh0002_0000, 32'd7, 1'b1));
        drain();
    endtask

    task automatic test_zero_gravity();
        write_reg(REG_GRAV_CONST, 64'h0);
        send_body(mk_body(32'sh0, 32'sh0001_0000, 32'sh0, 32'hFFFF_FFFF, 1'b0));
        send_body(mk_body(32'sh0, 32'sh0, 32'sh0001_0000, 32'hFFFF_FFFF, 1'b1));
        drain();
    endtask

    task automatic test_spare_register_index();
        write_reg(REG_GRAV_CONST, 64'h0100_0000);
        write_reg(REG_SPARE_A, 64'hDEAD_BEEF_DEAD_BEEF);
        write_reg(REG_SPARE_B, 64'hFFFF_FFFF_FFFF_FFFF);
        send_body(mk_body(32'sh0002_0000, 32'sh0, 32'sh0, 32'd300, 1'b0));
        send_body(mk_body(-32'sh0002_0000, 32'sh0, 32'sh0, 32'd100, 1'b1));
        drain();
    endtask

    task automatic test_store_full();
        // 66 loads: the last two are dropped, the flagged one still starts the set
        logic [31:0] center;
        write_reg(REG_GRAV_CONST, 64'h0040_0000);
        write_reg(REG_SOFTENING_SQ, 64'h0000_0000_1000_0000);
        center = $urandom();
        for (int n = 0; n < STORE_DEPTH + 2; n++)
            send_body(rand_body(center, n == STORE_DEPTH + 1));
        drain();
    endtask

    task automatic test_random_sets(input int n_items);
        int          sent;
        int          size;
        logic [31:0] center;
        sent = 0;
        while (sent < n_items) begin
            size = ($urandom_range(15) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
            center = $urandom();
            for (int n = 0; n < size; n++)
                send_body(rand_body(center, n == size - 1));
            sent += size;
        end
        drain();
    endtask

    task automatic random_config();
        case ($urandom_range(2))
            0: write_reg(REG_GRAV_CONST, {32'b0, $urandom()});
            1: write_reg(REG_GRAV_CONST, 64'hFFFF_FFFF);
            default: write_reg(REG_GRAV_CONST, {32'b0, 32'($urandom_range(1, 32'h00FF_FFFF))});
        endcase
        case ($urandom_range(2))
            0: write_reg(REG_SOFTENING_SQ, 64'h0);
            1: write_reg(REG_SOFTENING_SQ, {$urandom(), $urandom()});
            default: write_reg(REG_SOFTENING_SQ, {32'b0, $urandom()});
        endcase
    endtask

    initial begin
        grav_shadow = '0;
        soft_shadow = '0;
        loaded = 0;
        requests_sent = 0;
        sets_done = 0;
        gap_pct = 26;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_body();
        test_coincident_and_saturation();
        test_zero_mass_and_extremes();
        test_zero_gravity();
        test_spare_register_index();
        test_store_full();

        // three random phases with different sender gap rates
        gap_pct = 26;
        random_config();
        test_random_sets(125);
        gap_pct = 57;
        random_config();
        test_random_sets(125);
        gap_pct = 0;
        random_config();
        test_random_sets(125);

        $display("covered %0d load requests in %0d body sets, %0d per-body results checked",
                 requests_sent, sets_done, results_seen);
        $display("including store overflow, coincident bodies, zero mass and saturation");
        if (error_count == 0 && accel_q.size() == 0)
            $display("tb_nbody_gravity_accel_core: done, clean");
        else
            $display("tb_nbody_gravity_accel_core: done, errors");
        $finish;
    end

endmodule
